FILE: rtl/core/abrpm_pkg.sv
// Shared constants and types for the burst RMS and peak level meter.
`timescale 1ns / 1ps

package abrpm_pkg;

    localparam int RAW_W           = 32;
    localparam int SAMPLE_SHIFT    = 8;
    localparam int MAG_W           = 24;
    localparam int SQ_W            = 2 * MAG_W;
    localparam int RMS_W           = 24;
    localparam int PEAK_W          = 24;
    localparam int COUNT_W         = 10;
    localparam int M_TDATA_W       = 64;
    localparam int MAX_SAMPLES_DEF = 512;
    localparam int QUEUE_DEPTH     = 4;
    localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SQRT = 4'b0100,
        ST_OUT  = 4'b1000
    } back_state_t;

endpackage

FILE: rtl/core/abrpm_front.sv
// Front pipeline: magnitude, square and per-burst accumulation.
`timescale 1ns / 1ps

module abrpm_front #(
    parameter int MAX_SAMPLES = abrpm_pkg::MAX_SAMPLES_DEF,
    parameter int CNT_W       = $clog2(MAX_SAMPLES + 1),
    parameter int SUM_W       = abrpm_pkg::SQ_W - 2 + CNT_W,
    parameter int ENTRY_W     = SUM_W + abrpm_pkg::PEAK_W + CNT_W
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [abrpm_pkg::RAW_W-1:0]    s_tdata,
    input  logic                           s_tlast,
    input  logic                           q_full,
    output logic                           push,
    output logic [ENTRY_W-1:0]             push_data
);
    import abrpm_pkg::*;

    logic              en;
    logic [MAG_W-1:0]  s24;
    logic [MAG_W-1:0]  mag;

    logic              v1_reg;
    logic [MAG_W-1:0]  mag1_reg;
    logic              last1_reg;
    logic              v2_reg;
    logic [SQ_W-1:0]   sq2_reg;
    logic [MAG_W-1:0]  mag2_reg;
    logic              last2_reg;

    logic [SUM_W-1:0]  sum_reg,  sum_next;
    logic [PEAK_W-1:0] peak_reg, peak_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              close;

    assign en       = !q_full;
    assign s_tready = en;

    assign s24 = s_tdata[RAW_W-1:SAMPLE_SHIFT];
    assign mag = s24[MAG_W-1] ? (~s24 + MAG_W'(1)) : s24;

    always_comb begin
        sum_next  = sum_reg + SUM_W'(sq2_reg);
        peak_next = (mag2_reg > peak_reg) ? mag2_reg : peak_reg;
        cnt_next  = cnt_reg + CNT_W'(1);
        close     = last2_reg || (cnt_next == CNT_W'(MAX_SAMPLES));
    end

    assign push      = en && v2_reg && close;
    assign push_data = {cnt_next, peak_next, sum_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            sum_reg  <= '0;
            peak_reg <= '0;
            cnt_reg  <= '0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            if (v2_reg) begin
                if (close) begin
                    sum_reg  <= '0;
                    peak_reg <= '0;
                    cnt_reg  <= '0;
                end else begin
                    sum_reg  <= sum_next;
                    peak_reg <= peak_next;
                    cnt_reg  <= cnt_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag1_reg  <= mag;
            last1_reg <= s_tlast;
            sq2_reg   <= mag1_reg * mag1_reg;
            mag2_reg  <= mag1_reg;
            last2_reg <= last1_reg;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg < CNT_W'(MAX_SAMPLES))
        else $error("open burst count reached the burst limit");

    a_peak_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> (peak_reg == '0 && sum_reg == '0))
        else $error("burst state not cleared after close");

endmodule

FILE: rtl/core/abrpm_queue.sv
// Short queue of closed-burst totals between front and back.
`timescale 1ns / 1ps

module abrpm_queue #(
    parameter int WIDTH = 90
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    output logic             not_empty,
    input  logic             pop,
    output logic [WIDTH-1:0] head
);
    import abrpm_pkg::*;

    logic [WIDTH-1:0]  entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;

    assign full      = (fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + (QPTR_W + 1)'(1);
            end else if (pop && !push) begin
                fill_reg <= fill_reg - (QPTR_W + 1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("pop from empty queue");

endmodule

FILE: rtl/core/abrpm_back.sv
// Back end: serial divide by count, serial integer square root, result register.
`timescale 1ns / 1ps

module abrpm_back #(
    parameter int CNT_W   = 10,
    parameter int SUM_W   = 56,
    parameter int ENTRY_W = SUM_W + abrpm_pkg::PEAK_W + CNT_W
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_not_empty,
    input  logic [ENTRY_W-1:0]                q_head,
    output logic                              pop,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [abrpm_pkg::M_TDATA_W-1:0]   m_tdata
);
    import abrpm_pkg::*;

    localparam int ROOT_W = (SUM_W + 1) / 2;
    localparam int OP_W   = 2 * ROOT_W;
    localparam int SREM_W = ROOT_W + 2;
    localparam int STEP_W = $clog2(SUM_W);

    back_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg;

    logic [SUM_W-1:0]  quo_reg;
    logic [CNT_W:0]    rem_reg;
    logic [CNT_W-1:0]  div_reg;
    logic [PEAK_W-1:0] peak_reg;
    logic [OP_W-1:0]   op_reg;
    logic [SREM_W-1:0] srem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [RMS_W-1:0]  rms_reg;

    logic [CNT_W:0]    rem_sh;
    logic              div_ge;
    logic [SUM_W-1:0]  quo_next;
    logic [SREM_W-1:0] srem_sh, trial;
    logic              sq_ge;
    logic [ROOT_W-1:0] root_next;
    logic [CNT_W+COUNT_W-1:0] cnt_ext;

    assign pop      = (state_reg == ST_IDLE) && q_not_empty;
    assign m_tvalid = (state_reg == ST_OUT);
    assign cnt_ext  = {{COUNT_W{1'b0}}, div_reg};
    assign m_tdata  = {(M_TDATA_W - RMS_W - PEAK_W - COUNT_W)'(0),
                       cnt_ext[COUNT_W-1:0], peak_reg, rms_reg};

    always_comb begin
        rem_sh    = {rem_reg[CNT_W-1:0], quo_reg[SUM_W-1]};
        div_ge    = rem_sh >= {1'b0, div_reg};
        quo_next  = {quo_reg[SUM_W-2:0], div_ge};
        srem_sh   = {srem_reg[ROOT_W-1:0], op_reg[OP_W-1 -: 2]};
        trial     = {root_reg, 2'b01};
        sq_ge     = srem_sh >= trial;
        root_next = {root_reg[ROOT_W-2:0], sq_ge};
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_not_empty) state_next = ST_DIV;
            ST_DIV:  if (step_reg == STEP_W'(SUM_W - 1)) state_next = ST_SQRT;
            ST_SQRT: if (step_reg == STEP_W'(ROOT_W - 1)) state_next = ST_OUT;
            ST_OUT:  if (m_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (state_next != state_reg) begin
                step_reg <= '0;
            end else begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                quo_reg  <= q_head[SUM_W-1:0];
                peak_reg <= q_head[SUM_W +: PEAK_W];
                div_reg  <= q_head[SUM_W+PEAK_W +: CNT_W];
                rem_reg  <= '0;
            end
            ST_DIV: begin
                quo_reg  <= quo_next;
                rem_reg  <= div_ge ? (rem_sh - {1'b0, div_reg}) : rem_sh;
                op_reg   <= OP_W'(quo_next);
                srem_reg <= '0;
                root_reg <= '0;
            end
            ST_SQRT: begin
                op_reg   <= op_reg << 2;
                srem_reg <= sq_ge ? (srem_sh - trial) : srem_sh;
                root_reg <= root_next;
                rms_reg  <= root_next[RMS_W-1:0];
            end
            ST_OUT: begin
            end
            default: begin
            end
        endcase
    end

    a_out_leaves_on_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (state_reg == ST_OUT))
        else $error("result dropped before it was taken");

    a_div_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (rem_reg < {1'b0, div_reg}))
        else $error("divide remainder not below divisor");

endmodule

FILE: rtl/core/audio_burst_rms_peak_meter_unit.sv
// Top level of the burst RMS and peak level meter.
`timescale 1ns / 1ps

// Takes one 32-bit microphone word per beat (audio in bits 31:8) and sums the
// squared sample magnitudes and tracks the peak over a burst that ends on a beat
// with s_tlast high or on the MAX_SAMPLES-th beat. The front pipeline accepts one
// beat per cycle while the queue is not full, three stages deep. Each closed burst
// enters a four-entry queue; the back end then divides by the count one quotient
// bit per cycle and takes the integer square root two operand bits per cycle,
// then holds the result until m_tready. The back end handles one burst at a time;
// bursts that close faster than it finishes them fill the queue, and then s_tready
// drops until the back end drains it.
// m_tdata carries rms in bits 23:0, peak in 47:24, sample count (low 10 bits) in
// 57:48.
module audio_burst_rms_peak_meter_unit #(
    parameter int MAX_SAMPLES = abrpm_pkg::MAX_SAMPLES_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [abrpm_pkg::RAW_W-1:0]      s_tdata,   // raw_word
    input  logic                             s_tlast,   // last_of_burst
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [abrpm_pkg::M_TDATA_W-1:0]  m_tdata    // rms_level, peak_level, sample_count
);
    import abrpm_pkg::*;

    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W   = SQ_W - 2 + CNT_W;
    localparam int ENTRY_W = SUM_W + PEAK_W + CNT_W;

    logic               q_full;
    logic               q_not_empty;
    logic               push;
    logic               pop;
    logic [ENTRY_W-1:0] push_data;
    logic [ENTRY_W-1:0] q_head;

    abrpm_front #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .CNT_W       (CNT_W),
        .SUM_W       (SUM_W),
        .ENTRY_W     (ENTRY_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    abrpm_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .not_empty (q_not_empty),
        .pop       (pop),
        .head      (q_head)
    );

    abrpm_back #(
        .CNT_W   (CNT_W),
        .SUM_W   (SUM_W),
        .ENTRY_W (ENTRY_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule

FILE: dv/tb_audio_burst_rms_peak_meter_unit.sv
// Self-checking testbench for the burst RMS and peak level meter.
`timescale 1ns / 1ps

module tb_audio_burst_rms_peak_meter_unit;

    localparam int BURST_MAX   = abrpm_pkg::MAX_SAMPLES_DEF;
    localparam int PHASE_BEATS = 24;
    localparam int RX_HOLD     = 400;
    localparam int DRAIN_WAIT  = 200;

    typedef struct packed {
        logic [abrpm_pkg::RAW_W-1:0] raw;
        logic                        last;
    } mic_beat_t;

    typedef struct packed {
        logic [abrpm_pkg::RMS_W-1:0]   rms;
        logic [abrpm_pkg::PEAK_W-1:0]  peak;
        logic [abrpm_pkg::COUNT_W-1:0] count;
    } level_report_t;

    logic                               aclk     = 1'b0;
    logic                               aresetn  = 1'b0;
    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [abrpm_pkg::RAW_W-1:0]        s_tdata  = '0;
    logic                               s_tlast  = 1'b0;
    logic                               m_tvalid;
    logic                               m_tready = 1'b0;
    logic [abrpm_pkg::M_TDATA_W-1:0]    m_tdata;

    mic_beat_t     pending_beats[$];
    level_report_t expected_reports[$];

    // running burst state of the predictor
    logic [63:0] burst_sq_sum = '0;
    logic [23:0] burst_peak   = '0;
    int          burst_len    = 0;

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  s_taken = 1'b0;
    bit  rx_hold_go = 1'b0;
    bit  rx_hold_done = 1'b0;
    int  rx_hold_left = 0;
    int  errors = 0;
    int  beats_in = 0;
    int  reports_checked = 0;
    int  full_closes = 0;
    mic_beat_t drv_beat;

    audio_burst_rms_peak_meter_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // raw_word
        .s_tlast  (s_tlast),    // last_of_burst
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // rms_level, peak_level, sample_count, zero pad
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    initial begin
        #5ms;
        $display("Timeout at %0t: %0d reports still outstanding", $time,
                 expected_reports.size());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [23:0] floor_root(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = 23; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) begin
                root = trial;
            end
        end
        return root[23:0];
    endfunction

    task automatic predict_level(input mic_beat_t beat);
        logic [23:0]   smp;
        logic [23:0]   mag;
        level_report_t rep;
        smp = beat.raw[31:8];
        mag = smp[23] ? (~smp + 24'd1) : smp;
        burst_sq_sum += 64'(mag) * 64'(mag);
        if (mag > burst_peak) begin
            burst_peak = mag;
        end
        burst_len++;
        if (beat.last || burst_len == BURST_MAX) begin
            if (!beat.last) begin
                full_closes++;
            end
            rep.rms   = floor_root(burst_sq_sum / 64'(burst_len));
            rep.peak  = burst_peak;
            rep.count = burst_len[9:0];
            expected_reports.push_back(rep);
            burst_sq_sum = '0;
            burst_peak   = '0;
            burst_len    = 0;
        end
    endtask

    // input driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                drv_beat = pending_beats.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= drv_beat.raw;
                s_tlast  <= drv_beat.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver, with one long hold-off on request
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready <= 1'b0;
        end else if (rx_hold_go && !rx_hold_done) begin
            rx_hold_done <= 1'b1;
            rx_hold_left <= RX_HOLD;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor and checker
    always @(posedge aclk) begin
        level_report_t want;
        level_report_t got;
        s_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            beats_in++;
            predict_level('{raw: s_tdata, last: s_tlast});
        end
        if (aresetn && m_tvalid && m_tready) begin
            got.rms   = m_tdata[23:0];
            got.peak  = m_tdata[47:24];
            got.count = m_tdata[57:48];
            if (expected_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected report rms=%0d peak=%0d count=%0d", $time,
                         got.rms, got.peak, got.count);
            end else begin
                want = expected_reports.pop_front();
                reports_checked++;
                if (got.rms !== want.rms || got.peak !== want.peak
                        || got.count !== want.count || m_tdata[63:58] !== 6'd0) begin
                    errors++;
                    $display("%0t: report mismatch: expected rms=%0d peak=%0d count=%0d pad=0",
                             $time, want.rms, want.peak, want.count);
                    $display("%0t:                  actual rms=%0d peak=%0d count=%0d pad=%0d",
                             $time, got.rms, got.peak, got.count, m_tdata[63:58]);
                end
            end
        end
    end

    function automatic logic [31:0] pick_word();
        int v;
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h0000_00FF;
                    3: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0000;
                endcase
            end
            1: begin
                v = int'($urandom_range(2000)) - 1000;
                return {v[23:0], 8'($urandom)};
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic add_burst(input int len);
        for (int i = 0; i < len; i++) begin
            pending_beats.push_back('{raw: pick_word(), last: (i == len - 1)});
        end
    endtask

    task automatic add_beat(input logic [31:0] raw, input logic last);
        pending_beats.push_back('{raw: raw, last: last});
    endtask

    task automatic drain_all();
        while (pending_beats.size() != 0 || s_tvalid) @(posedge aclk);
        while (expected_reports.size() != 0) @(posedge aclk);
    endtask

    initial begin
        int phase_beats;
        int r;
        wait (aresetn);
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            if (ph == 0) begin
                // single-beat bursts at the field extremes
                add_beat(32'h8000_0000, 1'b1);
                add_beat(32'h7FFF_FFFF, 1'b1);
                add_beat(32'h0000_00FF, 1'b1);
                add_beat(32'hFFFF_FFFF, 1'b1);
                add_beat(32'h0000_0000, 1'b1);
                // most negative samples only: rms reaches 2^23
                add_beat(32'h8000_0000, 1'b0);
                add_beat(32'h8000_00FF, 1'b0);
                add_beat(32'h8000_0000, 1'b1);
                add_beat(32'h8000_0000, 1'b0);
                add_beat(32'h7FFF_FF00, 1'b0);
                add_beat(32'h0000_0000, 1'b1);
                add_beat(32'h0000_0100, 1'b0);
                add_beat(32'hFFFF_FF00, 1'b0);
                add_beat(32'h1234_5678, 1'b0);
                add_beat(32'hEDCB_A987, 1'b1);
                add_beat(32'h0000_0000, 1'b0);
                add_beat(32'h0000_007F, 1'b1);
                rx_hold_go = 1'b1;
            end
            phase_beats = 0;
            while (phase_beats < PHASE_BEATS) begin
                r = $urandom_range(9);
                if (r < 7) begin
                    r = $urandom_range(8, 1);
                end else if (r < 9) begin
                    r = $urandom_range(40, 9);
                end else begin
                    r = $urandom_range(120, 41);
                end
                add_burst(r);
                phase_beats += r;
            end
            if (ph == 1) begin
                // no end marker: closes on reaching the length limit
                for (int i = 0; i < BURST_MAX; i++) begin
                    add_beat(pick_word(), 1'b0);
                end
                add_burst(3);
            end
            drain_all();
        end
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (expected_reports.size() != 0) begin
            errors += expected_reports.size();
            $display("%0t: %0d expected reports never arrived", $time,
                     expected_reports.size());
        end
        $display("Ran %0d beats over four pacing phases; %0d burst reports checked,",
                 beats_in, reports_checked);
        $display("%0d closed at full length, one long receiver hold-off, %0d errors.",
                 full_closes, errors);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/abrpm_pkg.sv
rtl/core/abrpm_front.sv
rtl/core/abrpm_queue.sv
rtl/core/abrpm_back.sv
rtl/core/audio_burst_rms_peak_meter_unit.sv
dv/tb_audio_burst_rms_peak_meter_unit.sv
